### hdl/pwc_pkg.sv
`timescale 1ns / 1ps
// Power window controller package: request/result structs, motion state
// encoding, reverse counter sizing. No dependencies.

package pwc_pkg;

  // Width of the jam reverse counter and of the reverse length register.
  localparam int REVERSE_COUNT_BITS = 16;
  localparam int TICKS_BITS         = 16;
  localparam int REV_EXT_BITS       = (REVERSE_COUNT_BITS > TICKS_BITS) ?
                                      REVERSE_COUNT_BITS : TICKS_BITS;
  localparam logic [REVERSE_COUNT_BITS-1:0] REV_COUNT_MAX = '1;
  localparam logic [TICKS_BITS-1:0] JAM_TICKS_RESET = TICKS_BITS'(50);

  // Reported motion_state codes.
  localparam logic [2:0] CODE_IDLE        = 3'd0;
  localparam logic [2:0] CODE_UP_AUTO     = 3'd1;
  localparam logic [2:0] CODE_UP_MANUAL   = 3'd2;
  localparam logic [2:0] CODE_DOWN_AUTO   = 3'd3;
  localparam logic [2:0] CODE_DOWN_MANUAL = 3'd4;
  localparam logic [2:0] CODE_REVERSE     = 3'd5;

  typedef enum logic [5:0] {
    MODE_IDLE        = 6'b000001,
    MODE_UP_AUTO     = 6'b000010,
    MODE_UP_MANUAL   = 6'b000100,
    MODE_DOWN_AUTO   = 6'b001000,
    MODE_DOWN_MANUAL = 6'b010000,
    MODE_REVERSE     = 6'b100000
  } mode_t;

  typedef struct packed {
    logic pass_up_auto;
    logic pass_up_manual;
    logic pass_down_auto;
    logic pass_down_manual;
    logic drv_up_auto;
    logic drv_up_manual;
    logic drv_down_auto;
    logic drv_down_manual;
    logic passenger_lock;
    logic top_limit;
    logic bottom_limit;
    logic jam_sensor;
  } in_t;

  typedef struct packed {
    logic       motor_up;
    logic       motor_down;
    logic [2:0] motion_state;
  } out_t;

  // Controller state carried between ticks.
  typedef struct packed {
    mode_t                         mode;
    logic                          by_driver;
    logic [REVERSE_COUNT_BITS-1:0] count;
  } state_t;

endpackage

### hdl/power_window_controller.sv
`timescale 1ns / 1ps
// Power window controller top level: request register, tick logic,
// result register, state and reverse length register. Uses pwc_pkg, pwc_step.
//
// One request is one sample tick of the window buttons, lock, limit
// switches and jam sensor; each request yields exactly one result with the
// motor drive and motion state for that tick. The block takes one request
// per clock while in_stall is low: the request is registered, one pass of
// priority/limit logic (pwc_step) computes the next state, and the result
// lands in an output register. A result that is held by out_stall does not
// block intake while the request register is free; a stalled output backs
// up into in_stall once the request register holds a waiting request.
// The user must write the jam reverse length (cfg_wr_data, reset 50 ticks,
// 0 acts as 1) with cfg_wr_en only while no request is in flight; unenforced.

module power_window_controller (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  pwc_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output pwc_pkg::out_t                   out_data,
  input  logic                            cfg_wr_en,
  input  logic [pwc_pkg::TICKS_BITS-1:0]  cfg_wr_data
);

  // Reverse length register.
  logic [pwc_pkg::TICKS_BITS-1:0] jam_ticks;

  // Request register (stage 1).
  logic          s1_valid;
  pwc_pkg::in_t  s1_data;

  // Controller state.
  pwc_pkg::state_t st;
  pwc_pkg::state_t st_next;
  pwc_pkg::out_t   res;

  logic advance;   // stage 1 moves into the result register this cycle
  logic take;      // a new request is accepted this cycle

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      jam_ticks <= pwc_pkg::JAM_TICKS_RESET;
    end else if (cfg_wr_en) begin
      jam_ticks <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_data <= in_data;
    end
  end

  pwc_step u_step (
    .st        (st),
    .jam_ticks (jam_ticks),
    .req       (s1_data),
    .st_next   (st_next),
    .res       (res)
  );

  // State commits only when its tick's result is captured.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode      <= pwc_pkg::MODE_IDLE;
      st.by_driver <= 1'b0;
      st.count     <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

  // Never drive the motor both ways in a delivered result.
  a_motor_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.motor_up && out_data.motor_down))
    else $error("motor driven up and down at once");

  // A waiting request is neither lost nor overwritten.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_data)))
    else $error("stalled request lost or changed");

  // Jam reverse is entered only from an upward motion.
  a_rev_entry: assert property (@(posedge clk) disable iff (rst)
    (advance && st_next.mode == pwc_pkg::MODE_REVERSE &&
     st.mode != pwc_pkg::MODE_REVERSE) |->
    (st.mode == pwc_pkg::MODE_UP_AUTO || st.mode == pwc_pkg::MODE_UP_MANUAL))
    else $error("reverse entered outside upward motion");

  // State changes only when a tick is processed.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st))
    else $error("state changed without a tick");

endmodule

### hdl/pwc_step.sv
`timescale 1ns / 1ps
// One tick of the window controller: next state and motor outputs.
// Purely combinational. Depends on pwc_pkg.

module pwc_step (
  input  pwc_pkg::state_t                  st,
  input  logic [pwc_pkg::TICKS_BITS-1:0]   jam_ticks,
  input  pwc_pkg::in_t                     req,
  output pwc_pkg::state_t                  st_next,
  output pwc_pkg::out_t                    res
);

  logic                                        decided;
  logic                                        pass_ok;
  logic                                        held;
  logic [pwc_pkg::TICKS_BITS-1:0]              ticks_m1;
  logic [pwc_pkg::REV_EXT_BITS-1:0]            ticks_ext;
  logic [pwc_pkg::REVERSE_COUNT_BITS-1:0]      reload;
  pwc_pkg::mode_t                              m;
  logic                                        drv;
  logic [pwc_pkg::REVERSE_COUNT_BITS-1:0]      cnt;

  // Reverse reload: zero stays zero (one tick), oversize saturates.
  always_comb begin
    ticks_m1  = (jam_ticks == '0) ? '0 : jam_ticks - pwc_pkg::TICKS_BITS'(1);
    ticks_ext = pwc_pkg::REV_EXT_BITS'(ticks_m1);
    if (ticks_ext > pwc_pkg::REV_EXT_BITS'(pwc_pkg::REV_COUNT_MAX)) begin
      reload = pwc_pkg::REV_COUNT_MAX;
    end else begin
      reload = ticks_ext[pwc_pkg::REVERSE_COUNT_BITS-1:0];
    end
  end

  always_comb begin
    m       = st.mode;
    drv     = st.by_driver;
    cnt     = st.count;
    decided = 1'b0;
    pass_ok = !req.passenger_lock;
    held    = 1'b0;

    if (m == pwc_pkg::MODE_REVERSE) begin
      if (cnt != '0 && !req.bottom_limit) begin
        cnt     = cnt - pwc_pkg::REVERSE_COUNT_BITS'(1);
        decided = 1'b1;
      end else begin
        cnt = '0;
        m   = pwc_pkg::MODE_IDLE;
      end
    end

    // Jam only counts against an upward motion held at tick start.
    if (!decided && req.jam_sensor &&
        (m == pwc_pkg::MODE_UP_AUTO || m == pwc_pkg::MODE_UP_MANUAL)) begin
      cnt     = reload;
      m       = pwc_pkg::MODE_REVERSE;
      decided = 1'b1;
    end

    if (!decided) begin
      priority if (req.pass_up_auto && pass_ok) begin
        m = pwc_pkg::MODE_UP_AUTO;     drv = 1'b0;
      end else if (req.pass_up_manual && pass_ok) begin
        m = pwc_pkg::MODE_UP_MANUAL;   drv = 1'b0;
      end else if (req.pass_down_auto && pass_ok) begin
        m = pwc_pkg::MODE_DOWN_AUTO;   drv = 1'b0;
      end else if (req.pass_down_manual && pass_ok) begin
        m = pwc_pkg::MODE_DOWN_MANUAL; drv = 1'b0;
      end else if (req.drv_up_auto) begin
        m = pwc_pkg::MODE_UP_AUTO;     drv = 1'b1;
      end else if (req.drv_up_manual) begin
        m = pwc_pkg::MODE_UP_MANUAL;   drv = 1'b1;
      end else if (req.drv_down_auto) begin
        m = pwc_pkg::MODE_DOWN_AUTO;   drv = 1'b1;
      end else if (req.drv_down_manual) begin
        m = pwc_pkg::MODE_DOWN_MANUAL; drv = 1'b1;
      end else if (m == pwc_pkg::MODE_UP_MANUAL) begin
        // running manual motion keeps going on its own button, lock or not
        held = drv ? req.drv_up_manual : req.pass_up_manual;
        if (!held) begin
          m = pwc_pkg::MODE_IDLE;
        end
      end else if (m == pwc_pkg::MODE_DOWN_MANUAL) begin
        held = drv ? req.drv_down_manual : req.pass_down_manual;
        if (!held) begin
          m = pwc_pkg::MODE_IDLE;
        end
      end else begin
        // no button and no manual motion: mode stands
        held = 1'b0;
      end

      if ((m == pwc_pkg::MODE_UP_AUTO || m == pwc_pkg::MODE_UP_MANUAL) &&
          req.top_limit) begin
        m = pwc_pkg::MODE_IDLE;
      end
      if ((m == pwc_pkg::MODE_DOWN_AUTO || m == pwc_pkg::MODE_DOWN_MANUAL) &&
          req.bottom_limit) begin
        m = pwc_pkg::MODE_IDLE;
      end
    end

    st_next.mode      = m;
    st_next.by_driver = drv;
    st_next.count     = cnt;
  end

  always_comb begin
    res = '0;
    unique case (st_next.mode)
      pwc_pkg::MODE_UP_AUTO: begin
        res.motor_up = 1'b1;   res.motion_state = pwc_pkg::CODE_UP_AUTO;
      end
      pwc_pkg::MODE_UP_MANUAL: begin
        res.motor_up = 1'b1;   res.motion_state = pwc_pkg::CODE_UP_MANUAL;
      end
      pwc_pkg::MODE_DOWN_AUTO: begin
        res.motor_down = 1'b1; res.motion_state = pwc_pkg::CODE_DOWN_AUTO;
      end
      pwc_pkg::MODE_DOWN_MANUAL: begin
        res.motor_down = 1'b1; res.motion_state = pwc_pkg::CODE_DOWN_MANUAL;
      end
      pwc_pkg::MODE_REVERSE: begin
        res.motor_down = 1'b1; res.motion_state = pwc_pkg::CODE_REVERSE;
      end
      default: begin
        res.motion_state = pwc_pkg::CODE_IDLE;
      end
    endcase
  end

endmodule
